// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/fsq_pkg.sv -----
package fsq_pkg;

   // default sizes
   localparam int MAX_FRAMES_DEF = 64;
   localparam int TIME_BITS_DEF  = 24;

   // fixed field widths
   localparam int ACC_W     = 32;
   localparam int RECT_W    = 64;
   localparam int AMOUNT_W  = 24;
   localparam int INDEX_W   = 6;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;

   // item kinds
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_DELAY  = 2'd2;

   // clamp a 34-bit signed result to the signed 32-bit range
   function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W+1:0] v);
      logic [ACC_W-1:0] res;
      if (v[ACC_W+1:ACC_W-1] == 3'b000 || v[ACC_W+1:ACC_W-1] == 3'b111) begin
         res = v[ACC_W-1:0];
      end else if (v[ACC_W+1]) begin
         res = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(ACC_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ----- hdl/frame_animation_sequencer_top.sv -----
// channel   | direction | transfer contents
// ----------+-----------+------------------------------------------------------
// req_*     | in        | one frame append, tick or delay command
// rsp_*     | out       | current frame after each command
// csr_*     | in        | running bit, written any cycle
//
// append, delay, unused kinds and ticks that do not walk: the command passes through
// the fetch and response states to the output register. walking tick: the remainder
// unit runs, then one frame per cycle is stepped through the frame memory read port,
// fewer than the stored frame count, then the response state. one
// command at a time; a finished result waits in the output register while
// rsp_tready is low. synchronous reset empties the table and clears time and the
// current frame; the frame memory needs no sweep.
`include "assert_macros.svh"

module frame_animation_sequencer_top #(
   parameter int MAX_FRAMES = fsq_pkg::MAX_FRAMES_DEF,
   parameter int TIME_BITS  = fsq_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: rect_x, rect_y, rect_w, rect_h, time_amount
   input  logic [fsq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: mode
   input  logic [1:0]                      req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: frame_index, frame_x, frame_y, frame_width, frame_height, zero pad
   output logic [fsq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: table_empty, append_dropped, walk_stalled
   output logic [fsq_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data
);

   localparam int IDX_W   = $clog2(MAX_FRAMES);
   localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int TOT_W   = TIME_BITS + CNT_W;
   localparam int ACC_W   = fsq_pkg::ACC_W;
   localparam int RECT_W  = fsq_pkg::RECT_W;
   localparam int ENTRY_W = RECT_W + TIME_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic                          running_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              cur_ff, cur_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [TOT_W-1:0]              total_ff, total_in;
   logic                          dropped_ff, dropped_in;
   logic                          stalled_ff, stalled_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fsq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [fsq_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                          req_accept;
   logic [31:0]                   amount32;
   logic [TIME_BITS-1:0]          amount;
   logic [ACC_W+1:0]              amount34;
   logic [ACC_W+1:0]              acc34;
   logic [ACC_W-1:0]              acc_add;
   logic [ACC_W-1:0]              acc_sub;

   logic                          mem_we;
   logic [IDX_W-1:0]              rd_addr;
   logic [ENTRY_W-1:0]            rd_data;
   logic [TIME_BITS-1:0]          hold;
   logic [RECT_W-1:0]             rect;
   logic [63:0]                   hold64;
   logic [63:0]                   acc64;
   logic [CNT_W-1:0]              cur_p1;
   logic [IDX_W-1:0]              cur_next;
   logic [31:0]                   cur32;

   logic                          div_start;
   logic                          div_done;
   logic [TOT_W-1:0]              div_rem;
   logic [63:0]                   rem64;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // time amount masked to the configured width
   assign amount32 = {8'd0, req_tdata[RECT_W +: fsq_pkg::AMOUNT_W]};
   assign amount   = amount32[TIME_BITS-1:0];
   assign amount34 = {{(ACC_W + 2 - TIME_BITS){1'b0}}, amount};
   assign acc34    = {{2{acc_ff[ACC_W-1]}}, acc_ff};
   assign acc_add  = fsq_pkg::sat_acc(acc34 + amount34);
   assign acc_sub  = fsq_pkg::sat_acc(acc34 - amount34);

   // frame entry fields
   assign hold   = rd_data[RECT_W +: TIME_BITS];
   assign rect   = (count_ff != '0) ? rd_data[RECT_W-1:0] : '0;
   assign hold64 = {{(64 - TIME_BITS){1'b0}}, hold};
   assign acc64  = {32'd0, acc_ff};

   // wrap to the first frame past the last stored one
   assign cur_p1   = CNT_W'(cur_ff) + 1'b1;
   assign cur_next = (cur_p1 >= count_ff) ? '0 : cur_p1[IDX_W-1:0];
   assign cur32    = {{(32 - IDX_W){1'b0}}, cur_ff};

   assign rem64 = {{(64 - TOT_W){1'b0}}, div_rem};

   fsq_frame_mem #(
      .DEPTH  (MAX_FRAMES),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({amount, req_tdata[RECT_W-1:0]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // accumulator reduced by the lap total before stepping frames
   fsq_mod_unit #(
      .DVD_W (ACC_W - 1),
      .DVS_W (TOT_W)
   ) u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (acc_in[ACC_W-2:0]),
      .divisor   (total_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      dropped_in   = dropped_ff;
      stalled_in   = stalled_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      rd_addr      = cur_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dropped_in = 1'b0;
               stalled_in = 1'b0;
               state_in   = ST_FETCH;
               unique case (req_tuser)
                  fsq_pkg::MODE_APPEND: begin
                     if (count_ff >= CNT_W'(MAX_FRAMES)) begin
                        dropped_in = 1'b1;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                        total_in = total_ff + TOT_W'(amount);
                     end
                  end
                  fsq_pkg::MODE_TICK: begin
                     if (running_ff && count_ff != '0) begin
                        acc_in = acc_add;
                        if (!acc_add[ACC_W-1]) begin
                           if (total_ff == '0) begin
                              stalled_in = 1'b1;
                           end else begin
                              div_start = 1'b1;
                              state_in  = ST_DIV;
                           end
                        end
                     end
                  end
                  fsq_pkg::MODE_DELAY: begin
                     acc_in = acc_sub;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_DIV: begin
            if (div_done) begin
               acc_in   = rem64[ACC_W-1:0];
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // one frame per cycle; read data always belongs to cur_ff
            if (acc64 >= hold64) begin
               acc_in  = acc_ff - hold64[ACC_W-1:0];
               cur_in  = cur_next;
               rd_addr = cur_next;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, rect, cur32[fsq_pkg::INDEX_W-1:0]};
               rsp_user_in  = {stalled_ff, dropped_ff, (count_ff == '0)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         count_ff     <= '0;
         cur_ff       <= '0;
         acc_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         acc_ff       <= acc_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            running_ff <= csr_wr_data;
         end
      end
   end

   // result payload and per-command flags
   always_ff @(posedge clock) begin
      dropped_ff  <= dropped_in;
      stalled_ff  <= stalled_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `ASSERT_ALWAYS(a_count_range, count_ff <= CNT_W'(MAX_FRAMES), "frame count past table size")
   `ASSERT_ALWAYS(a_cur_in_table, count_ff == '0 || CNT_W'(cur_ff) < count_ff, "index past end")
   `ASSERT_ALWAYS(a_flags_exclusive, !(rsp_tvalid && rsp_tuser[1] && rsp_tuser[2]), "drop with stall")
   `ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "taken while busy")

endmodule

// ----- hdl/fsq_frame_mem.sv -----
module fsq_frame_mem #(
   parameter int DEPTH  = fsq_pkg::MAX_FRAMES_DEF,
   parameter int WIDTH  = fsq_pkg::RECT_W + fsq_pkg::TIME_BITS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fsq_mod_unit.sv -----
module fsq_mod_unit #(
   parameter int DVD_W = fsq_pkg::ACC_W - 1,
   parameter int DVS_W = fsq_pkg::TIME_BITS_DEF + 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVS_W-1:0] remainder
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   // one restoring step per cycle, dividend msb first
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         dvd_in  = dvd_ff << 1;
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- test/frame_animation_sequencer_checker.sv -----
module frame_animation_sequencer_checker
   import fsq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // tdata: rect_x, rect_y, rect_w, rect_h, time_amount
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: mode
   input  logic [1:0]             req_tuser,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // tdata: frame_index, frame_x, frame_y, frame_width, frame_height, zero pad
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: table_empty, append_dropped, walk_stalled
   input  logic [RSP_USER_W-1:0]  rsp_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ACC_HI = 64'sd2147483647;
   localparam longint ACC_LO = -ACC_HI - 1;

   // one frame report as the block should give it
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [15:0]        width;
      logic [15:0]        height;
      logic               empty;
      logic               dropped;
      logic               stalled;
   } frame_report_type;

   frame_report_type      frame_report_q[$];

   // shadow of the animation state
   logic [RECT_W-1:0]     rect_table [MAX_FRAMES_DEF];
   logic [AMOUNT_W-1:0]   hold_table [MAX_FRAMES_DEF];
   int                    frame_total;
   int                    shown_frame;
   longint                time_acc;
   logic                  running;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
   endfunction

   // tick: add elapsed time, then step frames while the time covers them
   function automatic logic advance_frames(input logic [AMOUNT_W-1:0] dt);
      longint elapsed;
      longint lap;
      longint rest;
      int     pos;
      elapsed = dt;
      if (!running || frame_total == 0) return 1'b0;
      time_acc = clamp_acc(time_acc + elapsed);
      if (time_acc < 0) return 1'b0;
      lap = 0;
      for (int i = 0; i < frame_total; i++) lap += longint'(hold_table[i]);
      if (lap == 0) return 1'b1;
      rest = time_acc % lap;
      pos  = (shown_frame >= frame_total) ? 0 : shown_frame;
      while (rest >= longint'(hold_table[pos])) begin
         rest -= longint'(hold_table[pos]);
         pos = (pos + 1 >= frame_total) ? 0 : pos + 1;
      end
      shown_frame = pos;
      time_acc    = rest;
      return 1'b0;
   endfunction

   // apply one command and build the report that follows it
   function automatic frame_report_type predict_frame(input logic [1:0] mode,
                                                      input logic [REQ_DATA_W-1:0] data);
      frame_report_type  rep;
      logic [RECT_W-1:0] rect;
      longint            amount;
      rep    = '0;
      rect   = '0;
      amount = data[REQ_DATA_W-1:RECT_W];
      case (mode)
         MODE_APPEND: begin
            if (frame_total >= MAX_FRAMES_DEF) begin
               rep.dropped = 1'b1;
            end else begin
               rect_table[frame_total] = data[RECT_W-1:0];
               hold_table[frame_total] = data[REQ_DATA_W-1:RECT_W];
               frame_total++;
            end
         end
         MODE_TICK: begin
            rep.stalled = advance_frames(data[REQ_DATA_W-1:RECT_W]);
         end
         MODE_DELAY: begin
            time_acc = clamp_acc(time_acc - amount);
         end
         default: begin
         end
      endcase
      if (frame_total != 0 && shown_frame < frame_total) rect = rect_table[shown_frame];
      rep.index  = shown_frame[INDEX_W-1:0];
      rep.x      = rect[15:0];
      rep.y      = rect[31:16];
      rep.width  = rect[47:32];
      rep.height = rect[63:48];
      rep.empty  = (frame_total == 0);
      return rep;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
   endtask

   // watch the channels at each rising edge
   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         frame_report_q.delete();
         frame_total = 0;
         shown_frame = 0;
         time_acc    = 0;
         running     = 1'b0;
         fail_count  = 0;
      end else begin
         if (csr_wr_en) running = csr_wr_data;
         if (req_tvalid && req_tready) begin
            frame_report_q = {frame_report_q, predict_frame(req_tuser, req_tdata)};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (frame_report_q.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected result transfer, expected none actual 0x%0h/0x%0h",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = frame_report_q.pop_front();
               check_field("frame_index",    want.index,   rsp_tdata[5:0]);
               check_field("frame_x",        want.x,       rsp_tdata[21:6]);
               check_field("frame_y",        want.y,       rsp_tdata[37:22]);
               check_field("frame_width",    want.width,   rsp_tdata[53:38]);
               check_field("frame_height",   want.height,  rsp_tdata[69:54]);
               check_field("table_empty",    want.empty,   rsp_tuser[0]);
               check_field("append_dropped", want.dropped, rsp_tuser[1]);
               check_field("walk_stalled",   want.stalled, rsp_tuser[2]);
            end
         end
      end
      outstanding = frame_report_q.size();
   end

endmodule

// ----- test/tb_frame_animation_sequencer_top.sv -----
module tb_frame_animation_sequencer_top
   import fsq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         DRAIN_CYCLES   = 20;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [1:0]            req_tuser   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;

   int                    fail_count;
   int                    outstanding;
   int                    quiet_cycles = 0;
   int                    req_sent     = 0;
   bit                    req_calm     = 1'b0;

   always #2 clock = ~clock;

   frame_animation_sequencer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frame_animation_sequencer_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // stop the run when the channels go quiet for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls, with calm stretches
   initial begin
      int gap;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock iff rsp_tvalid);
         taken++;
      end
   end

   // hold time or elapsed time, mostly small, sometimes the full range
   function automatic logic [AMOUNT_W-1:0] draw_amount();
      case ($urandom_range(0, 7))
         0:       return '0;
         5:       return AMOUNT_W'($urandom_range(0, 1000));
         6:       return AMOUNT_W'($urandom);
         7:       return '1;
         default: return AMOUNT_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [RECT_W-1:0] draw_rect();
      return {$urandom, $urandom};
   endfunction

   // one command transfer after a random gap
   task automatic send_cmd(input logic [1:0] mode, input logic [RECT_W-1:0] rect,
                           input logic [AMOUNT_W-1:0] amount);
      int gap;
      if (req_sent % 32 == 0) req_calm = ($urandom_range(0, 3) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {amount, rect};
      @(posedge clock iff req_tready);
      req_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_running(input logic value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // frozen after reset, empty table
      send_cmd(MODE_TICK,  '1, '1);
      send_cmd(MODE_DELAY, '0, '0);
      send_cmd(MODE_SPARE, '0, '0);

      // running, empty table, then a lap of zero hold times
      set_running(1'b1);
      send_cmd(MODE_TICK,   '0, '1);
      send_cmd(MODE_APPEND, '1, '0);
      send_cmd(MODE_APPEND, '0, '0);
      send_cmd(MODE_TICK,   draw_rect(), '0);
      send_cmd(MODE_TICK,   draw_rect(), '1);
      send_cmd(MODE_DELAY,  draw_rect(), '1);
      send_cmd(MODE_DELAY,  draw_rect(), '1);
      send_cmd(MODE_TICK,   draw_rect(), AMOUNT_W'(1));
      send_cmd(MODE_SPARE,  '1, '1);

      // drive the time down to the negative limit, then up to the positive one
      for (int i = 0; i < 140; i++) begin
         send_cmd(MODE_DELAY, draw_rect(), AMOUNT_W'($urandom_range(24'hF00000, 24'hFFFFFF)));
      end
      for (int i = 0; i < 280; i++) begin
         send_cmd(MODE_TICK, draw_rect(), AMOUNT_W'($urandom_range(24'hF00000, 24'hFFFFFF)));
      end

      // frozen ticks before and after the lap becomes nonzero, then whole laps removed at once
      set_running(1'b0);
      send_cmd(MODE_TICK,   draw_rect(), '1);
      send_cmd(MODE_APPEND, draw_rect(), AMOUNT_W'(3));
      send_cmd(MODE_TICK,   draw_rect(), '1);
      set_running(1'b1);
      send_cmd(MODE_APPEND, draw_rect(), '1);
      send_cmd(MODE_TICK,   draw_rect(), '0);

      // random mix; the table fills up and later appends get dropped
      for (int phase = 0; phase < 4; phase++) begin
         set_running(phase != 1);
         for (int i = 0; i < 110; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               send_cmd(MODE_APPEND, draw_rect(), draw_amount());
            end else if (pick < 70) begin
               send_cmd(MODE_TICK, draw_rect(), draw_amount());
            end else if (pick < 90) begin
               send_cmd(MODE_DELAY, draw_rect(),
                        ($urandom_range(0, 3) == 0) ? draw_amount()
                                                    : AMOUNT_W'($urandom_range(0, 15)));
            end else begin
               send_cmd(MODE_SPARE, draw_rect(), draw_amount());
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
